### design/btr_pkg.sv
// Package: shared types, constants and command/status structs of the rasterizer.
package btr_pkg;

    localparam int SCREEN_WIDTH_DEF     = 512;
    localparam int SCREEN_HEIGHT_DEF    = 512;
    localparam int COORD_FRAC_BITS_DEF  = 4;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;

    localparam int COLOR_W = 24;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_THIRD  = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_FIRST_RST  = 24'hFF0000;
    localparam logic [COLOR_W-1:0] COLOR_SECOND_RST = 24'h00FF00;
    localparam logic [COLOR_W-1:0] COLOR_THIRD_RST  = 24'h0000FF;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] first_x;
        logic signed [15:0] first_y;
        logic signed [15:0] second_x;
        logic signed [15:0] second_y;
        logic signed [15:0] third_x;
        logic signed [15:0] third_y;
    } t_in_item;

    typedef struct packed {
        logic [8:0] pixel_x;
        logic [8:0] pixel_y;
        logic       covered;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       idle;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch vertices and box, select area operands
        logic area;      // register area once products are ready
        logic edges;     // compute edge values for the current pixel
        logic div_start; // start both weight divisions
        logic blend;     // form color products
        logic finish;    // build result and advance the scan
        logic emit_idle; // build an idle result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_active;
        logic hit;       // current pixel lies strictly inside the triangle
        logic div_done;
    } t_status;

endpackage

### design/btr_div.sv
// Restoring divider: one quotient bit per cycle for the two barycentric weights.
module btr_div import btr_pkg::*; #(
    parameter int NUM_W = 52,
    parameter int DEN_W = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_quot, n_quot;
    logic [DEN_W:0]   r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy, r_done, n_done;
    logic [DEN_W:0]   w_trial;

    // One shift-subtract step per cycle.
    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_trial = {r_rem[DEN_W-1:0], r_quot[NUM_W-1]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_cnt  = CNT_W'(NUM_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_quot = {r_quot[NUM_W-2:0], 1'b0};
            if (w_trial >= {1'b0, r_den}) begin
                n_rem = w_trial - {1'b0, r_den};
                n_quot[0] = 1'b1;
            end else begin
                n_rem = w_trial;
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

    // A finished division never coincides with a running one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_done |-> !r_busy)
        else $error("divider done while busy");
endmodule

### design/btr_datapath.sv
// Datapath: vertex registers, box, scan counters, edge values, dividers and blend.
module btr_datapath import btr_pkg::*; #(
    parameter int SCREEN_WIDTH     = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT    = SCREEN_HEIGHT_DEF,
    parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  t_in_item           i_item,
    input  logic [COLOR_W-1:0] i_color_first,
    input  logic [COLOR_W-1:0] i_color_second,
    input  logic [COLOR_W-1:0] i_color_third,
    output t_status            o_status,
    output t_out_item          o_result
);
    localparam int SW    = $clog2(SCREEN_WIDTH) + 1;
    localparam int SH    = $clog2(SCREEN_HEIGHT) + 1;
    localparam int BW    = (SW > SH) ? SW : SH;           // signed box coordinate
    localparam int AW    = 36;                            // doubled area / edge
    localparam int EW    = 40;                            // edge value width
    localparam int NUM_W = EW + WEIGHT_FRAC_BITS;
    localparam int WW    = WEIGHT_FRAC_BITS + 2;          // weight width
    localparam int PW    = WW + 8;                        // color product width
    localparam int FB    = 16 - COORD_FRAC_BITS + 1;      // floored coordinate top bit
    localparam logic signed [FB:0] FMAX = (1 <<< COORD_FRAC_BITS) - 1;
    localparam t_out_item IDLE_RESULT = '{idle: 1'b1, default: '0};

    logic signed [15:0] r_vx [3];
    logic signed [15:0] r_vy [3];
    logic signed [AW-1:0] r_area;
    logic signed [BW-1:0] r_x0, r_y0, r_x1, r_y1, r_sx, r_sy;
    logic r_active;
    logic signed [33:0] r_pa, r_pb;
    logic signed [EW-1:0] r_ea, r_eb, r_ec;
    logic r_inside;
    logic [WW-1:0] r_wa, r_wb, r_wc;
    logic [PW+1:0] r_sum [3];
    t_out_item r_res;

    // Bounding box from the incoming vertices.
    logic signed [15:0] w_mnx, w_mxx, w_mny, w_mxy;
    logic signed [FB:0] w_fx0, w_fy0, w_cx1, w_cy1;
    logic signed [BW-1:0] w_bx0, w_by0, w_bx1, w_by1;

    function automatic logic signed [15:0] min3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a < b) ? a : b;
        return (c < m) ? c : m;
    endfunction
    function automatic logic signed [15:0] max3(input logic signed [15:0] a, b, c);
        logic signed [15:0] m;
        m = (a > b) ? a : b;
        return (c > m) ? c : m;
    endfunction
    function automatic logic signed [BW-1:0] clampv(input logic signed [FB:0] v,
                                                   input logic signed [FB:0] lo,
                                                   input logic signed [FB:0] hi);
        logic signed [FB:0] r;
        r = (v < lo) ? lo : ((v > hi) ? hi : v);
        return BW'(r);
    endfunction

    always_comb begin
        w_mnx = min3(i_item.first_x, i_item.second_x, i_item.third_x);
        w_mxx = max3(i_item.first_x, i_item.second_x, i_item.third_x);
        w_mny = min3(i_item.first_y, i_item.second_y, i_item.third_y);
        w_mxy = max3(i_item.first_y, i_item.second_y, i_item.third_y);
        w_fx0 = (FB+1)'(w_mnx >>> COORD_FRAC_BITS);
        w_fy0 = (FB+1)'(w_mny >>> COORD_FRAC_BITS);
        // The ceiling needs one bit above the coordinate for the rounding add.
        w_cx1 = (FB+1)'((17'(w_mxx) + 17'(FMAX)) >>> COORD_FRAC_BITS) - (FB+1)'(1);
        w_cy1 = (FB+1)'((17'(w_mxy) + 17'(FMAX)) >>> COORD_FRAC_BITS) - (FB+1)'(1);
        w_bx0 = clampv(w_fx0, '0, (FB+1)'(SCREEN_WIDTH - 1));
        w_by0 = clampv(w_fy0, '0, (FB+1)'(SCREEN_HEIGHT - 1));
        w_bx1 = clampv(w_cx1, (FB+1)'(-1), (FB+1)'(SCREEN_WIDTH - 1));
        w_by1 = clampv(w_cy1, (FB+1)'(-1), (FB+1)'(SCREEN_HEIGHT - 1));
    end

    // Edge u->v at point p: (uy-vy)*px + (vx-ux)*py + ux*vy - vx*uy.
    // Rewritten as (uy-vy)*(px-ux) + (vx-ux)*(py-uy), two products a cycle.
    logic signed [17:0] w_px, w_py;
    assign w_px = 18'(r_sx) <<< COORD_FRAC_BITS;
    assign w_py = 18'(r_sy) <<< COORD_FRAC_BITS;

    logic [1:0] r_ecnt;
    logic signed [16:0] w_dy, w_dx;
    logic signed [18:0] w_ox, w_oy;
    logic [1:0] ku, kv;
    always_comb begin
        ku = 2'd1; kv = 2'd2;
        case (r_ecnt)
            2'd1: begin ku = 2'd2; kv = 2'd0; end
            2'd2: begin ku = 2'd0; kv = 2'd1; end
            default: begin ku = 2'd1; kv = 2'd2; end
        endcase
        w_dy = 17'(r_vy[ku]) - 17'(r_vy[kv]);
        w_dx = 17'(r_vx[kv]) - 17'(r_vx[ku]);
        if (i_cmd.load) begin
            w_ox = 19'(i_item.first_x) - 19'(i_item.second_x);
            w_oy = 19'(i_item.first_y) - 19'(i_item.second_y);
            w_dy = 17'(i_item.second_y) - 17'(i_item.third_y);
            w_dx = 17'(i_item.third_x) - 17'(i_item.second_x);
        end else begin
            w_ox = 19'(w_px) - 19'(r_vx[ku]);
            w_oy = 19'(w_py) - 19'(r_vy[ku]);
        end
    end

    logic signed [35:0] w_ma, w_mb;
    assign w_ma = 36'(w_dy) * 36'(w_ox);
    assign w_mb = 36'(w_dx) * 36'(w_oy);

    logic signed [EW-1:0] w_esum;
    assign w_esum = EW'(r_pa) + EW'(r_pb);

    // Divider inputs: magnitudes of edges and area.
    logic [AW-1:0] w_amag;
    logic [EW-1:0] w_ma_mag, w_mb_mag;
    assign w_amag   = r_area[AW-1] ? AW'(-r_area) : AW'(r_area);
    assign w_ma_mag = r_ea[EW-1] ? EW'(-r_ea) : EW'(r_ea);
    assign w_mb_mag = r_eb[EW-1] ? EW'(-r_eb) : EW'(r_eb);

    logic da, db;
    logic [NUM_W-1:0] qa, qb;
    btr_div #(.NUM_W(NUM_W), .DEN_W(AW)) u_div_a (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num({w_ma_mag, WEIGHT_FRAC_BITS'(0)}), .i_den(w_amag),
        .o_done(da), .o_quot(qa));
    btr_div #(.NUM_W(NUM_W), .DEN_W(AW)) u_div_b (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.div_start),
        .i_num({w_mb_mag, WEIGHT_FRAC_BITS'(0)}), .i_den(w_amag),
        .o_done(db), .o_quot(qb));

    // Blend: wc = one - wa - wb (weights below one since the pixel is inside).
    logic [WW-1:0] w_one;
    assign w_one = WW'(1) << WEIGHT_FRAC_BITS;

    function automatic logic [7:0] sat(input logic [PW+1:0] s);
        logic [PW+1:0] t;
        t = s >> WEIGHT_FRAC_BITS;
        return (t > (PW+2)'(255)) ? 8'hFF : t[7:0];
    endfunction

    logic w_pos, w_neg;
    assign w_pos = !r_area[AW-1] && (r_area != '0) && !r_ea[EW-1] && (r_ea != '0)
                   && !r_eb[EW-1] && (r_eb != '0) && !r_ec[EW-1] && (r_ec != '0);
    assign w_neg = r_area[AW-1] && r_ea[EW-1] && r_eb[EW-1] && r_ec[EW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ecnt   <= '0;
            r_res    <= '0;
            r_inside <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
            r_area <= '0;
            r_x0 <= '0; r_y0 <= '0; r_x1 <= '0; r_y1 <= '0;
            r_sx <= '0; r_sy <= '0;
        end else begin
            r_pa <= 34'(w_ma);
            r_pb <= 34'(w_mb);
            if (i_cmd.load) begin
                r_vx[0] <= i_item.first_x;  r_vy[0] <= i_item.first_y;
                r_vx[1] <= i_item.second_x; r_vy[1] <= i_item.second_y;
                r_vx[2] <= i_item.third_x;  r_vy[2] <= i_item.third_y;
                r_x0 <= w_bx0; r_y0 <= w_by0; r_x1 <= w_bx1; r_y1 <= w_by1;
                r_sx <= w_bx0; r_sy <= w_by0;
                r_active <= (w_bx0 <= w_bx1) && (w_by0 <= w_by1);
                r_ecnt <= '0;
            end
            if (i_cmd.area) r_area <= AW'(w_esum);
            // Edges: the three in turn, one per cycle, a product register ahead.
            if (i_cmd.edges) begin
                case (r_ecnt)
                    2'd0: r_ecnt <= 2'd1;
                    2'd1: begin r_ea <= w_esum; r_ecnt <= 2'd2; end
                    2'd2: begin r_eb <= w_esum; r_ecnt <= 2'd3; end
                    default: begin r_ec <= w_esum; r_ecnt <= 2'd0; end
                endcase
            end
            r_inside <= w_pos || w_neg;
            if (da) begin
                r_wa <= WW'(qa);
                r_wb <= WW'(qb);
                r_wc <= w_one - WW'(qa) - WW'(qb);
            end
            if (i_cmd.blend) begin
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= (PW+2)'(i_color_first[16-8*k +: 8] * r_wa)
                              + (PW+2)'(i_color_second[16-8*k +: 8] * r_wb)
                              + (PW+2)'(i_color_third[16-8*k +: 8] * r_wc);
                end
            end
            if (i_cmd.emit_idle) begin
                r_res <= IDLE_RESULT;
            end
            if (i_cmd.finish) begin
                r_res.pixel_x <= 9'(r_sx);
                r_res.pixel_y <= 9'(r_sy);
                r_res.covered <= r_inside;
                r_res.red   <= r_inside ? sat(r_sum[0]) : 8'd0;
                r_res.green <= r_inside ? sat(r_sum[1]) : 8'd0;
                r_res.blue  <= r_inside ? sat(r_sum[2]) : 8'd0;
                r_res.idle  <= 1'b0;
                r_res.last  <= (r_sy >= r_y1) && (r_sx >= r_x1);
                if (r_sy < r_y1) begin
                    r_sy <= r_sy + 1'b1;
                end else if (r_sx < r_x1) begin
                    r_sx <= r_sx + 1'b1;
                    r_sy <= r_y0;
                end else begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    assign o_status.scan_active = r_active;
    assign o_status.hit         = w_pos || w_neg;
    assign o_status.div_done    = da && db;
    assign o_result             = r_res;

    // The scan point stays inside the box while a scan is active.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_sx >= r_x0) && (r_sx <= r_x1) && (r_sy >= r_y0) && (r_sy <= r_y1))
        else $error("scan point left box");
    // Both dividers finish together.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) da == db)
        else $error("dividers out of step");
endmodule

### design/btr_ctrl.sv
// Controller: sequences load, edge evaluation, division, blend and result transfer.
module btr_ctrl import btr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_mode,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_valid,
    input  logic    i_out_stall
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AREA  = 7'b0000010,
        S_EDGE  = 7'b0000100,
        S_TEST  = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_BLEND = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_ecnt, n_ecnt;
    logic r_valid, n_valid;
    logic w_take;

    // Accept only when idle and the result register is free.
    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign w_take  = i_valid && !o_stall;

    always_comb begin
        n_state = r_state;
        n_ecnt  = r_ecnt;
        n_valid = r_valid && i_out_stall;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    if (i_mode == MODE_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state = S_AREA;
                    end else if (!i_status.scan_active) begin
                        o_cmd.emit_idle = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        o_cmd.edges = 1'b1;
                        n_ecnt = 2'd0;
                        n_state = S_EDGE;
                    end
                end
            end
            S_AREA: begin
                o_cmd.area = 1'b1;
                o_cmd.emit_idle = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_EDGE: begin
                o_cmd.edges = 1'b1;
                n_ecnt = r_ecnt + 1'b1;
                if (r_ecnt == 2'd2) n_state = S_TEST;
            end
            S_TEST: begin
                if (i_status.hit) begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_DIV: begin
                if (i_status.div_done) n_state = S_BLEND;
            end
            S_BLEND: begin
                o_cmd.blend = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ecnt  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ecnt  <= n_ecnt;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

    // No new item is taken while a result waits.
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_valid |-> o_stall)
        else $error("accepted with result pending");
    // A result appears only after a finishing or idle command.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(o_cmd.finish || o_cmd.emit_idle))
        else $error("result without command");
    // A division starts only for a covered pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> i_status.hit)
        else $error("division for uncovered pixel");
endmodule

### design/barycentric_triangle_rasterizer.sv
// Top level: barycentric triangle rasterizer with color blending.
//
//   channel   direction  handshake              payload
//   input     in         i_valid / o_stall      i_item (t_in_item)
//   output    out        o_valid / i_stall      o_result (t_out_item)
//   config    in         i_cfg_we               i_cfg_index, i_cfg_data
//
// A load registers the area, then gives an idle result. A step with no scan
// gives one directly. An uncovered pixel passes edges, test and finish;
// a covered pixel adds division and blend: the two shift-subtract dividers
// form one weight bit per cycle over the 56-bit dividend.
// One item is in work at a time; o_stall is high until its result is taken.
// Reset is synchronous and active low; it ends any scan and restores colors.
module barycentric_triangle_rasterizer import btr_pkg::*; #(
    parameter int SCREEN_WIDTH     = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT    = SCREEN_HEIGHT_DEF,
    parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = WEIGHT_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  t_in_item             i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_out_item            o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);
    logic [COLOR_W-1:0] r_c0, r_c1, r_c2;
    t_cmd    w_cmd;
    t_status w_status;

    // Color registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c0 <= COLOR_FIRST_RST;
            r_c1 <= COLOR_SECOND_RST;
            r_c2 <= COLOR_THIRD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_COLOR_FIRST:  r_c0 <= i_cfg_data;
                REG_COLOR_SECOND: r_c1 <= i_cfg_data;
                REG_COLOR_THIRD:  r_c2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    btr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_mode(i_item.mode),
        .o_stall(o_stall), .i_status(w_status), .o_cmd(w_cmd),
        .o_valid(o_valid), .i_out_stall(i_stall));

    btr_datapath #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .COORD_FRAC_BITS(COORD_FRAC_BITS), .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_item(i_item),
        .i_color_first(r_c0), .i_color_second(r_c1), .i_color_third(r_c2),
        .o_status(w_status), .o_result(o_result));
endmodule

### tb/barycentric_triangle_rasterizer_test.sv
// Testbench for the barycentric triangle rasterizer: directed and random triangles, self-checking.
module barycentric_triangle_rasterizer_test;
    import btr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_ITEMS = 650;

    // Expected-pixel tracker: mirrors the scan state and the color registers.
    class raster_scoreboard;
        logic [23:0] colors[3];
        int verts[6];
        longint tri_area;
        int box[4];
        int col, row;
        bit scanning;
        t_out_item pixel_q[$];
        int mismatches, checked, covered_seen, loads_seen;

        function new();
            colors[0] = COLOR_FIRST_RST;
            colors[1] = COLOR_SECOND_RST;
            colors[2] = COLOR_THIRD_RST;
            foreach (verts[i]) verts[i] = 0;
            foreach (box[i]) box[i] = 0;
            tri_area = 0;
            col = 0;
            row = 0;
            scanning = 0;
            mismatches = 0;
            checked = 0;
            covered_seen = 0;
            loads_seen = 0;
        endfunction

        function void set_color(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
            if (idx == REG_COLOR_FIRST) colors[0] = value;
            else if (idx == REG_COLOR_SECOND) colors[1] = value;
            else if (idx == REG_COLOR_THIRD) colors[2] = value;
        endfunction

        // Edge function of point (px,py) against the directed edge u -> v.
        function longint edge_fn(longint px, longint py, int u, int v);
            longint ux, uy, vx, vy;
            ux = verts[2*u]; uy = verts[2*u+1];
            vx = verts[2*v]; vy = verts[2*v+1];
            return (uy - vy) * px + (vx - ux) * py + ux * vy - vx * uy;
        endfunction

        function int clamp(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Work out the expected result of one accepted input transfer.
        function void note(t_in_item it);
            t_out_item exp_px;
            int mnx, mny, mxx, mxy;
            longint ea, eb, ec;
            longint unsigned mag_area, wa, wb, wc, s;
            exp_px = '0;
            if (it.mode == MODE_LOAD) begin
                loads_seen++;
                verts[0] = it.first_x;  verts[1] = it.first_y;
                verts[2] = it.second_x; verts[3] = it.second_y;
                verts[4] = it.third_x;  verts[5] = it.third_y;
                mnx = verts[0]; mxx = verts[0]; mny = verts[1]; mxy = verts[1];
                for (int k = 1; k < 3; k++) begin
                    if (verts[2*k] < mnx) mnx = verts[2*k];
                    if (verts[2*k] > mxx) mxx = verts[2*k];
                    if (verts[2*k+1] < mny) mny = verts[2*k+1];
                    if (verts[2*k+1] > mxy) mxy = verts[2*k+1];
                end
                tri_area = edge_fn(verts[0], verts[1], 1, 2);
                box[0] = clamp(mnx >>> 4, 0, 511);
                box[1] = clamp(mny >>> 4, 0, 511);
                box[2] = clamp(((mxx + 15) >>> 4) - 1, -1, 511);
                box[3] = clamp(((mxy + 15) >>> 4) - 1, -1, 511);
                col = box[0];
                row = box[1];
                scanning = box[0] <= box[2] && box[1] <= box[3];
                exp_px.idle = 1;
            end else if (!scanning) begin
                exp_px.idle = 1;
            end else begin
                ea = edge_fn(col * 16, row * 16, 1, 2);
                eb = edge_fn(col * 16, row * 16, 2, 0);
                ec = edge_fn(col * 16, row * 16, 0, 1);
                exp_px.pixel_x = col[8:0];
                exp_px.pixel_y = row[8:0];
                if ((tri_area > 0 && ea > 0 && eb > 0 && ec > 0) ||
                    (tri_area < 0 && ea < 0 && eb < 0 && ec < 0)) begin
                    mag_area = tri_area < 0 ? -tri_area : tri_area;
                    wa = ((ea < 0 ? -ea : ea) << 16) / mag_area;
                    wb = ((eb < 0 ? -eb : eb) << 16) / mag_area;
                    wc = (64'd1 << 16) - wa - wb;
                    exp_px.covered = 1;
                    for (int c = 0; c < 3; c++) begin
                        s = colors[0][16-8*c +: 8] * wa + colors[1][16-8*c +: 8] * wb
                          + colors[2][16-8*c +: 8] * wc;
                        s = s >> 16;
                        if (s > 255) s = 255;
                        if (c == 0) exp_px.red = s[7:0];
                        else if (c == 1) exp_px.green = s[7:0];
                        else exp_px.blue = s[7:0];
                    end
                end
                // Advance the scan: y inner, x outer.
                if (row < box[3]) begin
                    row++;
                end else if (col < box[2]) begin
                    col++;
                    row = box[1];
                end else begin
                    exp_px.last = 1;
                    scanning = 0;
                end
            end
            pixel_q = {pixel_q, exp_px};
        endfunction

        // Compare one output transfer with the oldest expected pixel.
        function void check(t_out_item got);
            t_out_item want;
            if (pixel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h with nothing expected", got);
                return;
            end
            want = pixel_q.pop_front();
            checked++;
            if (got.covered) covered_seen++;
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp x=%0d y=%0d cov=%0d rgb=%h%h%h last=%0d idle=%0d",
                             want.pixel_x, want.pixel_y, want.covered, want.red,
                             want.green, want.blue, want.last, want.idle,
                             " | got x=%0d y=%0d cov=%0d rgb=%h%h%h last=%0d idle=%0d",
                             got.pixel_x, got.pixel_y, got.covered, got.red,
                             got.green, got.blue, got.last, got.idle);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_stall;
    t_in_item i_item = '0;
    logic o_valid;
    logic i_stall = 0;
    t_out_item o_result;
    logic i_cfg_we = 0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COLOR_W-1:0] i_cfg_data = '0;

    raster_scoreboard pixels = new();
    int cycles = 0;
    int burst_left = 0;
    int items_sent = 0;

    barycentric_triangle_rasterizer i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_result(o_result),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #2 i_clk = 1;
        #2 i_clk = 0;
    end

    // Cycle counter with a hard timeout.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[barycentric_triangle_rasterizer] ERROR");
            $finish;
        end
    end

    // Receiver stall: the pattern follows bits 9:8 of the cycle count, some windows never stall.
    always @(posedge i_clk) begin
        case (cycles[9:8])
            2'd0: i_stall <= 1'b0;
            2'd1: i_stall <= ($urandom_range(99) < 30);
            2'd2: i_stall <= (cycles[2:0] < 3);
            default: i_stall <= ($urandom_range(99) < 70);
        endcase
    end

    // Output monitor.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            pixels.check(o_result);
    end

    // Send one input transfer, with bursts separated by random gaps.
    task automatic push_item(t_in_item it);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = $urandom_range(5, 0);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (o_stall);
        pixels.note(it);
        items_sent++;
    endtask

    // Let all pending pixels drain, then write the three color registers.
    task automatic write_colors(logic [23:0] c0, logic [23:0] c1, logic [23:0] c2);
        i_valid <= 1'b0;
        while (pixels.pixel_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        for (int k = 0; k < 3; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= (k == 0) ? REG_COLOR_FIRST : (k == 1) ? REG_COLOR_SECOND
                                                                 : REG_COLOR_THIRD;
            i_cfg_data <= (k == 0) ? c0 : (k == 1) ? c1 : c2;
            @(posedge i_clk);
            pixels.set_color((k == 0) ? REG_COLOR_FIRST : (k == 1) ? REG_COLOR_SECOND
                                                                   : REG_COLOR_THIRD,
                             (k == 0) ? c0 : (k == 1) ? c1 : c2);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_item step_item();
        t_in_item it;
        it = t_in_item'({$urandom(), $urandom(), $urandom(), $urandom()});
        it.mode = MODE_STEP;
        return it;
    endfunction

    function automatic t_in_item load_item(int ax, int ay, int bx, int by, int cx, int cy);
        t_in_item it;
        it.mode = MODE_LOAD;
        it.first_x = 16'(ax);  it.first_y = 16'(ay);
        it.second_x = 16'(bx); it.second_y = 16'(by);
        it.third_x = 16'(cx);  it.third_y = 16'(cy);
        return it;
    endfunction

    // Small triangle near or across the screen, occasionally full-range noise.
    function automatic t_in_item random_triangle();
        int bx, by, span;
        if ($urandom_range(99) < 8) begin
            return load_item($urandom(), $urandom(), $urandom(), $urandom(),
                             $urandom(), $urandom());
        end
        bx = $urandom_range(540) - 20;
        by = $urandom_range(540) - 20;
        if ($urandom_range(3) == 0) begin
            bx = $urandom_range(1) ? 507 : 1;
            by = $urandom_range(1) ? 507 : 1;
        end
        span = $urandom_range(96, 16);
        return load_item(bx * 16 + $urandom_range(span), by * 16 + $urandom_range(span),
                         bx * 16 + $urandom_range(span), by * 16 + $urandom_range(span),
                         bx * 16 + $urandom_range(span), by * 16 + $urandom_range(span));
    endfunction

    // Load, then step through the box, sometimes abandoning early.
    task automatic scan_triangle(t_in_item tri_item, int max_steps);
        int n;
        n = 0;
        push_item(tri_item);
        while (pixels.scanning && n < max_steps) begin
            push_item(step_item());
            n++;
        end
        repeat ($urandom_range(2)) push_item(step_item());
    endtask

    initial begin
        int sent_at_phase;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, extremes, edges and a degenerate triangle.
        push_item(step_item());
        scan_triangle(load_item(-32768, -32768, -32768, -32768, -32768, -32768), 4);
        scan_triangle(load_item(32767, 32767, 32767, 32767, 32767, 32767), 4);
        scan_triangle(load_item(-32768, -32768, 32767, -32768, -32768, 32767), 4);
        scan_triangle(load_item(16, 16, 64, 16, 16, 64), 12);
        scan_triangle(load_item(0, 0, 16, 16, 32, 32), 6);

        // Random part across several color settings.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                1: write_colors(24'h000000, 24'h000000, 24'h000000);
                2: write_colors(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
                3: write_colors($urandom(), $urandom(), $urandom());
                4: write_colors(24'h123456, 24'hFEDCBA, 24'h80FF01);
                default: ;
            endcase
            sent_at_phase = items_sent;
            while (items_sent - sent_at_phase < RANDOM_ITEMS / 5)
                scan_triangle(random_triangle(),
                              ($urandom_range(99) < 15) ? $urandom_range(6) : 60);
        end

        i_valid <= 1'b0;
        while (pixels.pixel_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        $display("sent %0d items in %0d loads; checked %0d results, %0d covered pixels",
                 items_sent, pixels.loads_seen, pixels.checked, pixels.covered_seen);
        $display("%0d mismatches over five color settings", pixels.mismatches);
        if (pixels.mismatches == 0 && pixels.pixel_q.size() == 0) begin
            $display("[barycentric_triangle_rasterizer] OK");
        end else begin
            $display("[barycentric_triangle_rasterizer] ERROR");
        end
        $finish;
    end
endmodule
